// ===== hw/rtl/idd_pkg.sv =====
// Shared types, constants and arithmetic helpers of the int8 dot/dequant column block.
package idd_pkg;

   localparam int DataWidth = 32;
   localparam int FmaLatency = 5;
   localparam int CntWidth = $clog2(FmaLatency + 1);
   localparam int CsrIndexWidth = 2;

   localparam logic [31:0] Fp32One = 32'h3F80_0000;
   localparam logic [31:0] Fp32NegZero = 32'h8000_0000;
   localparam logic [31:0] Fp32DefaultNan = 32'hFFC0_0000;
   localparam logic [31:0] Fp32QuietBit = 32'h0040_0000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ALPHA = 2'd0,
      CSR_BETA = 2'd1,
      CSR_OUT_BF16 = 2'd2
   } idd_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CVT,
      ST_SCALE,
      ST_ALPHA,
      ST_BETA,
      ST_DONE
   } idd_state_type;

   typedef enum logic [1:0] {
      OP_SCALE,
      OP_ALPHA,
      OP_BETA
   } idd_op_type;

   typedef struct packed {
      logic accum;
      logic cvt;
      idd_op_type op;
      logic load_val;
      logic emit;
   } idd_cmd_type;

   typedef struct packed {
      logic skip_alpha;
      logic skip_beta;
      logic out_busy;
   } idd_status_type;

   typedef struct packed {
      logic [7:0] act0;
      logic [7:0] act1;
      logic [7:0] act2;
      logic [7:0] act3;
      logic signed [7:0] wt0;
      logic signed [7:0] wt1;
      logic signed [7:0] wt2;
      logic signed [7:0] wt3;
      logic last;
      logic [31:0] col_scale;
      logic [31:0] col_bias;
      logic [31:0] old_value;
   } idd_req_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      n = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            n = 5'(23 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(31 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc52(input logic [51:0] v);
      logic [5:0] n;
      n = 6'd52;
      for (int i = 0; i < 52; i++) begin
         if (v[i]) begin
            n = 6'(51 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] int_to_fp32(input logic [31:0] v);
      logic sgn;
      logic [31:0] mag;
      logic [31:0] norm;
      logic [5:0] lz;
      logic [7:0] bexp;
      logic inc;
      logic [30:0] packed_bits;
      sgn = v[31];
      mag = sgn ? (~v + 32'd1) : v;
      lz = lzc32(mag);
      norm = mag << lz;
      bexp = 8'(8'd158 - {2'b0, lz});
      inc = norm[7] & ((|norm[6:0]) | norm[8]);
      packed_bits = {bexp, norm[30:8]} + {30'b0, inc};
      if (mag == 32'd0) begin
         return 32'd0;
      end
      return {sgn, packed_bits};
   endfunction

   function automatic logic [15:0] to_bf16(input logic [31:0] b);
      logic [31:0] rounded;
      rounded = b + 32'h0000_7FFF + {31'b0, b[16]};
      if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
         return b[31:16] | 16'h0040;
      end
      if (b[30:23] == 8'd0) begin
         return {b[31], 15'd0};
      end
      return rounded[31:16];
   endfunction

endpackage

// ===== hw/rtl/idd_req_if.sv =====
// Request channel: one activation/weight group with its column data.
interface idd_req_if;
   logic valid;
   logic ready;
   logic [7:0] act0;
   logic [7:0] act1;
   logic [7:0] act2;
   logic [7:0] act3;
   logic signed [7:0] wt0;
   logic signed [7:0] wt1;
   logic signed [7:0] wt2;
   logic signed [7:0] wt3;
   logic last;
   logic [31:0] col_scale;
   logic [31:0] col_bias;
   logic [31:0] old_value;

   modport source (output valid, act0, act1, act2, act3, wt0, wt1, wt2, wt3, last,
                   col_scale, col_bias, old_value, input ready);
   modport sink (input valid, act0, act1, act2, act3, wt0, wt1, wt2, wt3, last,
                 col_scale, col_bias, old_value, output ready);
endinterface

// ===== hw/rtl/idd_rsp_if.sv =====
// Response channel: one fp32 or bf16 column result.
interface idd_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] result_bits;

   modport source (output valid, result_bits, input ready);
   modport sink (input valid, result_bits, output ready);
endinterface

// ===== hw/rtl/int8_dot_dequant_column.sv =====
// Top level: one column of a u8 x s8 dot product with fp32 dequantization.
//
// req_bus carries one group of four activation and four weight bytes per
// transfer; the group's products add into a wrapping 32-bit accumulator.
// A non-last group leaves the block idle, and the next can follow right after.
// A group marked last starts the column epilogue: int-to-float conversion,
// then col_scale/col_bias FMA, optional alpha multiply and optional
// beta * old_value FMA, each on the shared 5-stage FMA unit. A last group
// occupies the block until its result is emitted, and only then is the
// next group taken; the emitted result is held in the output register
// that drives rsp_bus.
// rsp_bus holds one result in an output register; new groups are accepted
// while it waits. If the receiver still stalls when the next column ends,
// the block holds in its done state until the register frees.
// csr_* writes alpha (index 0), beta (1) and bf16 mode (2); write only idle.
// Reset (synchronous) clears the accumulator and drops any pending result;
// alpha returns to 1.0, beta to 0.0, output mode to fp32.
module int8_dot_dequant_column (
   input  logic                              clock,
   input  logic                              reset,
   idd_req_if.sink                           req_bus,
   idd_rsp_if.source                         rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [idd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [idd_pkg::DataWidth-1:0]     csr_wdata
);
   import idd_pkg::*;

   idd_req_type req_data;
   idd_cmd_type cmd;
   idd_status_type status;

   assign req_data = '{act0: req_bus.act0, act1: req_bus.act1, act2: req_bus.act2,
                       act3: req_bus.act3, wt0: req_bus.wt0, wt1: req_bus.wt1,
                       wt2: req_bus.wt2, wt3: req_bus.wt3, last: req_bus.last,
                       col_scale: req_bus.col_scale, col_bias: req_bus.col_bias,
                       old_value: req_bus.old_value};

   idd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   idd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_bits  (rsp_bus.result_bits)
   );
endmodule

// ===== hw/rtl/idd_fma.sv =====
// Five-stage fp32 fused multiply-add, round to nearest even, subnormals kept.
module idd_fma (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] op_c,
   output logic [31:0] result
);
   import idd_pkg::*;

   typedef struct packed {
      logic spec;
      logic [31:0] spec_val;
      logic sp;
      logic sc;
      logic c_zero;
      logic [47:0] prod;
      logic [11:0] ep_sum;
      logic [23:0] mc;
      logic [7:0] ec;
   } s1_type;

   typedef struct packed {
      logic spec;
      logic [31:0] spec_val;
      logic [47:0] x;
      logic [47:0] y;
      logic signed [11:0] e;
      logic sx;
      logic sy;
      logic [5:0] d;
   } s2_type;

   typedef struct packed {
      logic spec;
      logic [31:0] spec_val;
      logic [51:0] s;
      logic signed [11:0] e;
      logic sgn;
   } s3_type;

   typedef struct packed {
      logic spec;
      logic [31:0] spec_val;
      logic sgn;
      logic zero;
      logic ovf;
      logic [7:0] bexp;
      logic [22:0] frac;
      logic g;
      logic st;
   } s4_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   logic [31:0] result_ff, result_in;

   // unpack, classify, multiply
   always_comb begin
      logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero, sp;
      a_nan = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
      b_nan = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
      c_nan = (op_c[30:23] == 8'hFF) && (op_c[22:0] != 23'd0);
      a_inf = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
      b_inf = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
      c_inf = (op_c[30:23] == 8'hFF) && (op_c[22:0] == 23'd0);
      a_zero = (op_a[30:0] == 31'd0);
      b_zero = (op_b[30:0] == 31'd0);
      c_zero = (op_c[30:0] == 31'd0);
      sp = op_a[31] ^ op_b[31];
      s1_in.spec = 1'b1;
      s1_in.spec_val = Fp32DefaultNan;
      if (a_nan) begin
         s1_in.spec_val = op_a | Fp32QuietBit;
      end else if (b_nan) begin
         s1_in.spec_val = op_b | Fp32QuietBit;
      end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
         s1_in.spec_val = Fp32DefaultNan;
      end else if (c_nan) begin
         s1_in.spec_val = op_c | Fp32QuietBit;
      end else if (a_inf || b_inf) begin
         s1_in.spec_val = (c_inf && (op_c[31] != sp)) ? Fp32DefaultNan
                                                       : {sp, 8'hFF, 23'd0};
      end else if (c_inf) begin
         s1_in.spec_val = op_c;
      end else if (a_zero || b_zero) begin
         s1_in.spec_val = c_zero ? {sp & op_c[31], 31'd0} : op_c;
      end else begin
         s1_in.spec = 1'b0;
      end
      s1_in.sp = sp;
      s1_in.sc = op_c[31];
      s1_in.c_zero = c_zero;
      s1_in.prod = {op_a[30:23] != 8'd0, op_a[22:0]} * {op_b[30:23] != 8'd0, op_b[22:0]};
      s1_in.ep_sum = {4'b0, (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23]}
                   + {4'b0, (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23]};
      s1_in.mc = {op_c[30:23] != 8'd0, op_c[22:0]};
      s1_in.ec = (op_c[30:23] == 8'd0) ? 8'd1 : op_c[30:23];
   end

   // normalize both terms, pick the larger exponent
   always_comb begin
      logic [5:0] lzp;
      logic [4:0] lzc;
      logic [47:0] pn;
      logic [23:0] cn;
      logic signed [11:0] ep, ec, diff;
      lzp = lzc48(s1_ff.prod);
      lzc = lzc24(s1_ff.mc);
      pn = s1_ff.prod << lzp;
      cn = s1_ff.mc << lzc;
      ep = $signed(s1_ff.ep_sum) - 12'sd300 - $signed({6'b0, lzp});
      ec = s1_ff.c_zero ? -12'sd1000
                        : $signed({4'b0, s1_ff.ec}) - 12'sd174 - $signed({7'b0, lzc});
      s2_in.spec = s1_ff.spec;
      s2_in.spec_val = s1_ff.spec_val;
      if (ep >= ec) begin
         s2_in.x = pn;
         s2_in.y = {cn, 24'd0};
         s2_in.e = ep;
         s2_in.sx = s1_ff.sp;
         s2_in.sy = s1_ff.sc;
         diff = ep - ec;
      end else begin
         s2_in.x = {cn, 24'd0};
         s2_in.y = pn;
         s2_in.e = ec;
         s2_in.sx = s1_ff.sc;
         s2_in.sy = s1_ff.sp;
         diff = ec - ep;
      end
      s2_in.d = (diff > 12'sd60) ? 6'd60 : diff[5:0];
   end

   // align and add
   always_comb begin
      logic [50:0] xg, yfull, ymask, yg;
      logic sticky;
      xg = {s2_ff.x, 3'b0};
      yfull = {s2_ff.y, 3'b0};
      ymask = (51'd1 << s2_ff.d) - 51'd1;
      sticky = |(yfull & ymask);
      yg = (yfull >> s2_ff.d) | {50'd0, sticky};
      s3_in.spec = s2_ff.spec;
      s3_in.spec_val = s2_ff.spec_val;
      s3_in.e = s2_ff.e;
      if (s2_ff.sx == s2_ff.sy) begin
         s3_in.s = {1'b0, xg} + {1'b0, yg};
         s3_in.sgn = s2_ff.sx;
      end else if (xg >= yg) begin
         s3_in.s = {1'b0, xg - yg};
         s3_in.sgn = s2_ff.sx;
      end else begin
         s3_in.s = {1'b0, yg - xg};
         s3_in.sgn = s2_ff.sy;
      end
   end

   // normalize, subnormal limit, guard and sticky
   always_comb begin
      logic [5:0] lz, rs;
      logic signed [11:0] lim, ebn, nrs;
      logic [51:0] t, rmask;
      logic xst;
      lz = lzc52(s3_ff.s);
      lim = s3_ff.e + 12'sd174;
      ebn = s3_ff.e + 12'sd175 - $signed({6'b0, lz});
      nrs = -lim;
      rs = (nrs > 12'sd60) ? 6'd60 : nrs[5:0];
      rmask = (52'd1 << rs) - 52'd1;
      xst = 1'b0;
      s4_in.ovf = 1'b0;
      s4_in.bexp = 8'd0;
      if ($signed({6'b0, lz}) <= lim) begin
         t = s3_ff.s << lz;
         s4_in.ovf = (ebn >= 12'sd255);
         s4_in.bexp = ebn[7:0];
      end else if (lim >= 12'sd0) begin
         t = s3_ff.s << lim[5:0];
      end else begin
         t = s3_ff.s >> rs;
         xst = |(s3_ff.s & rmask);
      end
      s4_in.spec = s3_ff.spec;
      s4_in.spec_val = s3_ff.spec_val;
      s4_in.sgn = s3_ff.sgn;
      s4_in.zero = (s3_ff.s == 52'd0);
      s4_in.frac = t[50:28];
      s4_in.g = t[27];
      s4_in.st = (|t[26:0]) | xst;
   end

   // round and pack
   always_comb begin
      logic inc;
      logic [30:0] packed_bits;
      inc = s4_ff.g & (s4_ff.st | s4_ff.frac[0]);
      packed_bits = {s4_ff.bexp, s4_ff.frac} + {30'd0, inc};
      if (s4_ff.spec) begin
         result_in = s4_ff.spec_val;
      end else if (s4_ff.zero) begin
         result_in = 32'd0;
      end else if (s4_ff.ovf) begin
         result_in = {s4_ff.sgn, 8'hFF, 23'd0};
      end else begin
         result_in = {s4_ff.sgn, packed_bits};
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

// ===== hw/rtl/idd_ctrl.sv =====
// Controller state machine: accumulate, convert, and sequence the shared FMA.
module idd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   input  idd_pkg::idd_status_type status,
   output idd_pkg::idd_cmd_type    cmd
);
   import idd_pkg::*;

   idd_state_type state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic fma_done;
   logic xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign xfer = req_valid & req_ready;
   assign fma_done = (cnt_ff == CntWidth'(FmaLatency));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = '0;
      cmd = '{accum: xfer, cvt: 1'b0, op: OP_SCALE, load_val: 1'b0, emit: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (xfer && req_last) begin
               state_in = ST_CVT;
            end
         end
         ST_CVT: begin
            cmd.cvt = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op = OP_SCALE;
            cnt_in = cnt_ff + 1'b1;
            if (fma_done) begin
               cmd.load_val = 1'b1;
               cnt_in = '0;
               state_in = !status.skip_alpha ? ST_ALPHA
                        : !status.skip_beta ? ST_BETA : ST_DONE;
            end
         end
         ST_ALPHA: begin
            cmd.op = OP_ALPHA;
            cnt_in = cnt_ff + 1'b1;
            if (fma_done) begin
               cmd.load_val = 1'b1;
               cnt_in = '0;
               state_in = !status.skip_beta ? ST_BETA : ST_DONE;
            end
         end
         ST_BETA: begin
            cmd.op = OP_BETA;
            cnt_in = cnt_ff + 1'b1;
            if (fma_done) begin
               cmd.load_val = 1'b1;
               cnt_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntWidth'(FmaLatency))
      else $error("fma wait counter overran");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status.out_busy) |=> (state_ff == ST_DONE))
      else $error("result left done state while output slot busy");
`endif
endmodule

// ===== hw/rtl/idd_dp.sv =====
// Datapath: accumulator, config registers, operand selection and output register.
module idd_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [idd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [idd_pkg::DataWidth-1:0]  csr_wdata,
   input  idd_pkg::idd_req_type           req_data,
   input  idd_pkg::idd_cmd_type           cmd,
   output idd_pkg::idd_status_type        status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [idd_pkg::DataWidth-1:0]  rsp_bits
);
   import idd_pkg::*;

   logic [31:0] alpha_ff, alpha_in;
   logic [31:0] beta_ff, beta_in;
   logic bf16_ff, bf16_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] scale_ff, scale_in;
   logic [31:0] bias_ff, bias_in;
   logic [31:0] old_ff, old_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_bits_ff, rsp_bits_in;
   logic signed [18:0] dot;
   logic [31:0] cold;
   logic [31:0] op_a, op_b, op_c, fma_out;

   assign dot = 19'($signed({1'b0, req_data.act0}) * req_data.wt0)
              + 19'($signed({1'b0, req_data.act1}) * req_data.wt1)
              + 19'($signed({1'b0, req_data.act2}) * req_data.wt2)
              + 19'($signed({1'b0, req_data.act3}) * req_data.wt3);

   assign cold = bf16_ff ? {old_ff[15:0], 16'd0} : old_ff;

   always_comb begin
      case (cmd.op)
         OP_SCALE: begin
            op_a = val_ff;
            op_b = scale_ff;
            op_c = bias_ff;
         end
         OP_ALPHA: begin
            op_a = val_ff;
            op_b = alpha_ff;
            op_c = Fp32NegZero;
         end
         OP_BETA: begin
            op_a = beta_ff;
            op_b = cold;
            op_c = val_ff;
         end
         default: begin
            op_a = val_ff;
            op_b = scale_ff;
            op_c = bias_ff;
         end
      endcase
   end

   idd_fma u_fma (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .op_c   (op_c),
      .result (fma_out)
   );

   always_comb begin
      alpha_in = alpha_ff;
      beta_in = beta_ff;
      bf16_in = bf16_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ALPHA: alpha_in = csr_wdata;
            CSR_BETA: beta_in = csr_wdata;
            CSR_OUT_BF16: bf16_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      acc_in = acc_ff;
      val_in = val_ff;
      scale_in = scale_ff;
      bias_in = bias_ff;
      old_in = old_ff;
      if (cmd.accum) begin
         acc_in = acc_ff + {{13{dot[18]}}, dot};
         scale_in = req_data.col_scale;
         bias_in = req_data.col_bias;
         old_in = req_data.old_value;
      end
      if (cmd.cvt) begin
         val_in = int_to_fp32(acc_ff);
         acc_in = '0;
      end
      if (cmd.load_val) begin
         val_in = fma_out;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_bits_in = rsp_bits_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in = bf16_ff ? {16'd0, to_bf16(val_ff)} : val_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= Fp32One;
         beta_ff <= '0;
         bf16_ff <= 1'b0;
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff <= beta_in;
         bf16_ff <= bf16_in;
         acc_ff <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      scale_ff <= scale_in;
      bias_ff <= bias_in;
      old_ff <= old_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   assign status.skip_alpha = (alpha_ff == Fp32One);
   assign status.skip_beta = (beta_ff[30:0] == 31'd0);
   assign status.out_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bits = rsp_bits_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      cmd.cvt |=> (acc_ff == 32'd0))
      else $error("accumulator not cleared after conversion");
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");
`endif
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the int8 dot-product dequantization column block.
`timescale 1ns / 1ps

module tb_top;
   import idd_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [31:0] Fp32PosInf = 32'h7F80_0000;
   localparam logic [31:0] Fp32NegInf = 32'hFF80_0000;
   localparam logic [31:0] Fp32Zero = 32'h0000_0000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [DataWidth-1:0] csr_wdata;

   idd_req_if req_bus();
   idd_rsp_if rsp_bus();

   int8_dot_dequant_column DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   idd_req_type pending_groups[$];
   logic [31:0] want_results[$];
   logic [31:0] alpha_reg;
   logic [31:0] beta_reg;
   logic bf16_mode;
   logic [31:0] dot_sum;
   int mismatches;
   int groups_taken;
   int columns_done;
   bit calm;
   bit req_took;
   int send_gap;
   int stall_cnt;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic bit is_nan(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 23'd0;
   endfunction

   function automatic bit is_inf(logic [31:0] b);
      return b[30:0] == 31'h7F80_0000;
   endfunction

   function automatic logic [31:0] quieted(logic [31:0] b);
      return b | Fp32QuietBit;
   endfunction

   function automatic logic [63:0] widen(logic [31:0] b);
      logic [22:0] m;
      int k;
      m = b[22:0];
      if (b[30:23] == 8'hFF) return {b[31], 11'h7FF, m, 29'd0};
      if (b[30:23] != 8'd0) return {b[31], 11'(int'(b[30:23]) + 896), m, 29'd0};
      if (m == 23'd0) return {b[31], 63'd0};
      k = 22;
      while (!m[22]) begin
         m = m << 1;
         k = k - 1;
      end
      m = m << 1;
      return {b[31], 11'(k - 149 + 1023), m, 29'd0};
   endfunction

   function automatic logic [31:0] narrow(logic [63:0] d);
      logic [53:0] sig;
      logic [53:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      int e;
      int sh;
      int fexp;
      if (d[62:52] == 11'h7FF) return {d[63], 31'h7F80_0000};
      if (d[62:0] == 63'd0) return {d[63], 31'd0};
      sig = {2'b01, d[51:0]};
      e = int'(d[62:52]) - 1023;
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) sh = 60;
      kept = sig >> sh;
      rem = 64'(sig) & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 54'd1;
      if (e < -126) return {d[63], 31'd0} + 32'(kept);
      fexp = e + 127;
      if (kept[24]) begin
         kept = kept >> 1;
         fexp = fexp + 1;
      end
      if (fexp >= 255) return {d[63], 31'h7F80_0000};
      return {d[63], 8'(fexp), kept[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      real p;
      if (is_nan(a)) return quieted(a);
      if (is_nan(b)) return quieted(b);
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
         return Fp32DefaultNan;
      p = $bitstoreal(widen(a)) * $bitstoreal(widen(b));
      return narrow($realtobits(p));
   endfunction

   function automatic logic [31:0] fp_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      real p;
      real q;
      real s;
      real t;
      real err;
      logic [63:0] sb;
      if (is_nan(a)) return quieted(a);
      if (is_nan(b)) return quieted(b);
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
         return Fp32DefaultNan;
      if (is_nan(c)) return quieted(c);
      p = $bitstoreal(widen(a)) * $bitstoreal(widen(b));
      q = $bitstoreal(widen(c));
      s = p + q;
      sb = $realtobits(s);
      if (sb[62:52] == 11'h7FF) return (sb[51:0] != 52'd0) ? Fp32DefaultNan : narrow(sb);
      if (s == 0.0) return narrow(sb);
      t = s - p;
      err = (p - (s - t)) + (q - t);
      if (err != 0.0 && !sb[0]) begin
         if ((err > 0.0) == (s > 0.0)) sb = sb + 64'd1;
         else sb = sb - 64'd1;
      end
      return narrow(sb);
   endfunction

   function automatic logic [15:0] round_bf16(logic [31:0] b);
      logic [31:0] r;
      if (is_nan(b)) return b[31:16] | 16'h0040;
      if (b[30:23] == 8'd0) return {b[31], 15'd0};
      r = b + 32'h0000_7FFF + {31'd0, b[16]};
      return r[31:16];
   endfunction

   task automatic absorb_group(input idd_req_type g);
      logic [31:0] v;
      logic [31:0] prior;
      int signed dot;
      dot = int'(g.act0) * int'(g.wt0) + int'(g.act1) * int'(g.wt1)
          + int'(g.act2) * int'(g.wt2) + int'(g.act3) * int'(g.wt3);
      dot_sum = dot_sum + 32'(dot);
      groups_taken++;
      if (!g.last) return;
      v = narrow($realtobits($itor($signed(dot_sum))));
      v = fp_fma(v, g.col_scale, g.col_bias);
      if (alpha_reg != Fp32One) v = fp_mul(v, alpha_reg);
      if (beta_reg[30:0] != 31'd0) begin
         prior = bf16_mode ? {g.old_value[15:0], 16'd0} : g.old_value;
         v = fp_fma(beta_reg, prior, v);
      end
      want_results.push_back(bf16_mode ? {16'd0, round_bf16(v)} : v);
      dot_sum = 32'd0;
      columns_done++;
   endtask

   function automatic int draw_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_fp();
      case ($urandom_range(0, 15))
         0: return Fp32Zero;
         1: return Fp32NegZero;
         2: return Fp32PosInf;
         3: return Fp32NegInf;
         4: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         5: return {1'($urandom), 8'h00, 23'($urandom)};
         6: return Fp32One;
         7: return $urandom;
         default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic idd_req_type make_group(logic [7:0] a, logic [7:0] w, logic last_flag,
                                              logic [31:0] scale, logic [31:0] bias,
                                              logic [31:0] old);
      idd_req_type g;
      g.act0 = a;
      g.act1 = a;
      g.act2 = a;
      g.act3 = a;
      g.wt0 = w;
      g.wt1 = w;
      g.wt2 = w;
      g.wt3 = w;
      g.last = last_flag;
      g.col_scale = scale;
      g.col_bias = bias;
      g.old_value = old;
      return g;
   endfunction

   function automatic idd_req_type rand_group(logic last_flag);
      idd_req_type g;
      g.act0 = rand_byte();
      g.act1 = rand_byte();
      g.act2 = rand_byte();
      g.act3 = rand_byte();
      g.wt0 = rand_byte();
      g.wt1 = rand_byte();
      g.wt2 = rand_byte();
      g.wt3 = rand_byte();
      g.last = last_flag;
      g.col_scale = rand_fp();
      g.col_bias = rand_fp();
      g.old_value = rand_fp();
      return g;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ALPHA: alpha_reg = data;
         CSR_BETA: beta_reg = data;
         CSR_OUT_BF16: bf16_mode = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_groups.size() != 0 || req_bus.valid || want_results.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic queue_columns(input int count);
      int n;
      int len;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 20);
         for (int i = 1; i <= len; i++) pending_groups.push_back(rand_group(i == len));
         n += len;
      end
   endtask

   always @(negedge clock) begin
      idd_req_type g;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_took) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_groups.size() != 0) begin
            g = pending_groups.pop_front();
            req_bus.act0 <= g.act0;
            req_bus.act1 <= g.act1;
            req_bus.act2 <= g.act2;
            req_bus.act3 <= g.act3;
            req_bus.wt0 <= g.wt0;
            req_bus.wt1 <= g.wt1;
            req_bus.wt2 <= g.wt2;
            req_bus.wt3 <= g.wt3;
            req_bus.last <= g.last;
            req_bus.col_scale <= g.col_scale;
            req_bus.col_bias <= g.col_bias;
            req_bus.old_value <= g.old_value;
            req_bus.valid <= 1'b1;
            send_gap <= draw_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || stall_cnt == 0) begin
         rsp_bus.ready <= 1'b1;
         if (!reset && $urandom_range(0, 3) == 0) stall_cnt <= draw_gap();
      end else begin
         rsp_bus.ready <= 1'b0;
         stall_cnt <= stall_cnt - 1;
      end
   end

   always @(posedge clock) begin
      idd_req_type g;
      logic [31:0] want;
      req_took <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         g.act0 = req_bus.act0;
         g.act1 = req_bus.act1;
         g.act2 = req_bus.act2;
         g.act3 = req_bus.act3;
         g.wt0 = req_bus.wt0;
         g.wt1 = req_bus.wt1;
         g.wt2 = req_bus.wt2;
         g.wt3 = req_bus.wt3;
         g.last = req_bus.last;
         g.col_scale = req_bus.col_scale;
         g.col_bias = req_bus.col_bias;
         g.old_value = req_bus.old_value;
         absorb_group(g);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (want_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: result_bits %h", rsp_bus.result_bits);
         end else begin
            want = want_results.pop_front();
            if (rsp_bus.result_bits !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result_bits mismatch: expected %h, got %h", want,
                           rsp_bus.result_bits);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_ALPHA;
      csr_wdata = 32'd0;
      req_bus.valid = 1'b0;
      req_bus.act0 = 8'd0;
      req_bus.act1 = 8'd0;
      req_bus.act2 = 8'd0;
      req_bus.act3 = 8'd0;
      req_bus.wt0 = 8'sd0;
      req_bus.wt1 = 8'sd0;
      req_bus.wt2 = 8'sd0;
      req_bus.wt3 = 8'sd0;
      req_bus.last = 1'b0;
      req_bus.col_scale = 32'd0;
      req_bus.col_bias = 32'd0;
      req_bus.old_value = 32'd0;
      rsp_bus.ready = 1'b1;
      alpha_reg = Fp32One;
      beta_reg = 32'd0;
      bf16_mode = 1'b0;
      dot_sum = 32'd0;
      mismatches = 0;
      groups_taken = 0;
      columns_done = 0;
      calm = 1'b0;
      req_took = 1'b0;
      send_gap = 0;
      stall_cnt = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      pending_groups.push_back(make_group(8'hFF, 8'h7F, 1'b0, Fp32One, Fp32Zero, 32'd0));
      pending_groups.push_back(make_group(8'hFF, 8'h7F, 1'b1, Fp32One, Fp32Zero, 32'd0));
      pending_groups.push_back(make_group(8'hFF, 8'h80, 1'b1, Fp32One, Fp32NegZero, 32'd0));
      pending_groups.push_back(make_group(8'h00, 8'h00, 1'b1, Fp32PosInf, Fp32Zero, 32'd0));
      pending_groups.push_back(make_group(8'h01, 8'h01, 1'b1, 32'h7FA0_0001, Fp32One, 32'd0));
      pending_groups.push_back(make_group(8'h01, 8'h80, 1'b1, Fp32One, 32'hFFC0_1234, 32'd0));
      pending_groups.push_back(make_group(8'h03, 8'h05, 1'b1, 32'h0000_0001, Fp32NegZero,
                                          32'd0));
      pending_groups.push_back(make_group(8'hFF, 8'h7F, 1'b1, 32'h7F7F_FFFF, Fp32Zero, 32'd0));
      pending_groups.push_back(make_group(8'h10, 8'h10, 1'b1, Fp32PosInf, Fp32NegInf, 32'd0));
      pending_groups.push_back(make_group(8'hFF, 8'h81, 1'b1, Fp32One, 32'h0000_0001, 32'd0));
      pending_groups.push_back(make_group(8'h00, 8'h00, 1'b1, Fp32NegZero, Fp32NegZero, 32'd0));
      pending_groups.push_back(make_group(8'h7B, 8'hC3, 1'b1, 32'h3DCC_CCCD, 32'h4049_0FDB,
                                          32'd0));
      wait_idle();

      calm = 1'b1;
      for (int i = 0; i < 40; i++)
         pending_groups.push_back(make_group(8'hFF, 8'h7F, 1'b0, Fp32One, Fp32Zero, 32'd0));
      pending_groups.push_back(make_group(8'hFF, 8'h7F, 1'b1, Fp32One, Fp32Zero, 32'd0));
      wait_idle();

      for (int phase = 0; phase < 9; phase++) begin
         calm = (phase % 3 == 2);
         case (phase)
            0: begin
               csr_write(CSR_ALPHA, Fp32One);
               csr_write(CSR_BETA, 32'd0);
               csr_write(CSR_OUT_BF16, 32'd0);
            end
            1: begin
               csr_write(CSR_ALPHA, {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)});
               csr_write(CSR_BETA, {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)});
            end
            2: begin
               csr_write(CSR_ALPHA, Fp32NegZero);
               csr_write(CSR_BETA, Fp32NegZero);
               csr_write(CSR_OUT_BF16, {31'($urandom), 1'b1});
            end
            3: begin
               csr_write(CSR_ALPHA, 32'h7FA0_0000);
               csr_write(CSR_BETA, 32'h7FC1_2345);
               csr_write(CSR_OUT_BF16, {31'($urandom), 1'b0});
            end
            4: begin
               csr_write(CSR_ALPHA, 32'hFFFF_FFFF);
               csr_write(CSR_BETA, 32'hFFFF_FFFF);
               csr_write(CSR_OUT_BF16, 32'hFFFF_FFFF);
            end
            5: begin
               csr_write(CSR_ALPHA, 32'h0000_0001);
               csr_write(CSR_BETA, 32'h7F7F_FFFF);
               csr_write(CSR_OUT_BF16, 32'd0);
            end
            6: begin
               csr_write(CSR_ALPHA, rand_fp());
               csr_write(CSR_BETA, rand_fp());
               csr_write(CSR_OUT_BF16, $urandom);
               csr_write(CSR_UNUSED, $urandom);
            end
            7: begin
               csr_write(CSR_ALPHA, Fp32One);
               csr_write(CSR_BETA, 32'd0);
               csr_write(CSR_OUT_BF16, 32'd1);
            end
            default: begin
               csr_write(CSR_ALPHA, 32'd0);
               csr_write(CSR_BETA, Fp32One);
               csr_write(CSR_OUT_BF16, 32'd0);
            end
         endcase
         queue_columns(195);
         wait_idle();
      end

      repeat (40) @(posedge clock);
      $display("covered %0d groups over %0d columns, nine register settings and one long",
               groups_taken, columns_done);
      $display("column of peak products; %0d mismatches", mismatches);
      if (mismatches == 0 && want_results.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/idd_pkg.sv
hw/rtl/idd_req_if.sv
hw/rtl/idd_rsp_if.sv
hw/rtl/idd_fma.sv
hw/rtl/idd_ctrl.sv
hw/rtl/idd_dp.sv
hw/rtl/int8_dot_dequant_column.sv
test/tb_top.sv
